FILE: rtl/core/pcanon_pkg.sv
`default_nettype none

package pcanon_pkg;

   localparam int LEN_W         = 9;
   localparam int BYTE_W        = 8;
   localparam int DEF_BUF_DEPTH = 256;
   localparam int FIT_SLACK     = 2;

   localparam logic [LEN_W-1:0]  MAX_LEN_RST = 9'd256;

   localparam logic [BYTE_W-1:0] NUL_CH   = 8'h00;
   localparam logic [BYTE_W-1:0] DOT_CH   = 8'h2E;
   localparam logic [BYTE_W-1:0] SLASH_CH = 8'h2F;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // component-so-far pattern
   localparam logic [1:0] DOT_NONE = 2'd0;
   localparam logic [1:0] DOT_ONE  = 2'd1;
   localparam logic [1:0] DOT_TWO  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_WCHK,
      ST_HOLD
   } pcanon_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic walk_step;
      logic walk_check;
      logic rsp_load;
   } pcanon_cmd_type;

   typedef struct packed {
      logic walk_start;
      logic walk_floor;
      logic walk_slash;
   } pcanon_sts_type;

endpackage

`default_nettype wire

FILE: rtl/core/pcanon_ctrl.sv
`default_nettype none

module pcanon_ctrl
   import pcanon_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output pcanon_cmd_type cmd,
   input  pcanon_sts_type sts
);

   pcanon_state_type state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.walk_start) begin
               state_in = ST_WALK;
            end else if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (!sts.walk_floor) begin
               state_in = ST_WCHK;
            end else if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_WCHK: begin
            cmd.walk_check = 1'b1;
            if (!sts.walk_slash) begin
               state_in = ST_WALK;
            end else if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pcanon_dp.sv
`default_nettype none

module pcanon_dp
   import pcanon_pkg::*;
#(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  pcanon_cmd_type    cmd,
   output pcanon_sts_type    sts,
   input  logic              req_type,
   input  logic [BYTE_W-1:0] req_path_byte,
   input  logic [BYTE_W-1:0] req_read_index,
   input  logic              csr_valid,
   input  logic [LEN_W-1:0]  csr_max_len,
   output logic [LEN_W-1:0]  rsp_path_len,
   output logic              rsp_path_done,
   output logic              rsp_truncated,
   output logic [BYTE_W-1:0] rsp_read_byte
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam int SW = ((LEN_W > CW) ? LEN_W : CW) + 2;

   logic [BYTE_W-1:0] mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;

   logic [LEN_W-1:0]  max_len_ff, max_len_in;
   logic              type_ff, type_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [BYTE_W-1:0] index_ff, index_in;
   logic [LEN_W-1:0]  ol_ff, ol_in;
   logic              abs_ff, abs_in;
   logic              start_ff, start_in;
   logic [CW-1:0]     cl_ff, cl_in;
   logic [1:0]        dp_ff, dp_in;
   logic              stop_ff, stop_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic              done_ff, done_in;
   logic [BYTE_W-1:0] rb_ff, rb_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_trunc_ff, rsp_trunc_in;
   logic [BYTE_W-1:0] rsp_rb_ff, rsp_rb_in;

   // state as seen by this byte, after a new-path reset where due
   logic [LEN_W-1:0]  e_ol;
   logic              e_abs;
   logic [CW-1:0]     e_cl;
   logic [1:0]        e_dp;
   logic              e_stop;
   logic              sep;
   logic [SW-1:0]     lim;
   logic [SW-1:0]     fit_sum;
   logic [SW-1:0]     idx;
   logic              fit_fail;
   logic              is_push;

   // results of the push
   logic [LEN_W-1:0]  ex_ol;
   logic              ex_start;
   logic [CW-1:0]     ex_cl;
   logic [1:0]        ex_dp;
   logic              ex_stop;
   logic              ex_done;
   logic              ex_walk;
   logic              walk_floor;
   logic              walk_slash;

   assign is_push = (type_ff == REQ_PUSH);

   always_comb begin
      if (start_ff) begin
         e_ol   = '0;
         e_abs  = (byte_ff == SLASH_CH);
         e_cl   = '0;
         e_dp   = DOT_NONE;
         e_stop = 1'b0;
      end else begin
         e_ol   = ol_ff;
         e_abs  = abs_ff;
         e_cl   = cl_ff;
         e_dp   = dp_ff;
         e_stop = stop_ff;
      end
   end

   assign sep      = (e_ol > LEN_W'(e_abs));
   assign lim      = (SW'(max_len_ff) < SW'(BUF_DEPTH)) ? SW'(max_len_ff) : SW'(BUF_DEPTH);
   assign fit_sum  = SW'(e_ol) + SW'(e_cl) + SW'(FIT_SLACK);
   assign fit_fail = (fit_sum > lim);
   assign idx      = SW'(e_ol) + SW'(sep) + SW'(e_cl);

   always_comb begin
      ex_ol    = e_ol;
      ex_start = 1'b0;
      ex_cl    = e_cl;
      ex_dp    = e_dp;
      ex_stop  = e_stop;
      ex_done  = 1'b0;
      ex_walk  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = SLASH_CH;
      if (start_ff && (byte_ff == SLASH_CH)) begin
         // root slash
         ex_ol = LEN_W'(1);
         wr_en = 1'b1;
      end else if ((byte_ff == SLASH_CH) || (byte_ff == NUL_CH)) begin
         if (!e_stop && (e_cl != '0)) begin
            if ((e_cl == CW'(1)) && (e_dp == DOT_ONE)) begin
               // drop "."
            end else if ((e_cl == CW'(2)) && (e_dp == DOT_TWO)) begin
               ex_walk = sep;
            end else if (fit_fail) begin
               ex_stop = 1'b1;
            end else begin
               ex_ol   = LEN_W'(idx);
               wr_en   = sep;
               wr_addr = AW'(e_ol);
            end
         end
         if (!e_stop) begin
            ex_cl = '0;
            ex_dp = DOT_NONE;
         end
         if (byte_ff == NUL_CH) begin
            ex_cl    = '0;
            ex_dp    = DOT_NONE;
            ex_start = 1'b1;
            ex_done  = 1'b1;
         end
      end else if (!e_stop) begin
         // stage the byte past the committed length
         wr_en   = (idx < SW'(BUF_DEPTH));
         wr_addr = AW'(idx);
         wr_data = byte_ff;
         if ((byte_ff == DOT_CH) && (e_cl == '0)) begin
            ex_dp = DOT_ONE;
         end else if ((byte_ff == DOT_CH) && (e_cl == CW'(1)) && (e_dp == DOT_ONE)) begin
            ex_dp = DOT_TWO;
         end else begin
            ex_dp = DOT_NONE;
         end
         if (e_cl < CW'(BUF_DEPTH)) begin
            ex_cl = e_cl + CW'(1);
         end
      end
   end

   assign walk_floor = (k_ff <= LEN_W'(abs_ff));
   assign walk_slash = (rdata_ff == SLASH_CH);

   assign sts.walk_start = is_push && ex_walk;
   assign sts.walk_floor = walk_floor;
   assign sts.walk_slash = walk_slash;

   always_comb begin
      max_len_in = csr_valid ? csr_max_len : max_len_ff;
      type_in    = cmd.capture ? req_type : type_ff;
      byte_in    = cmd.capture ? req_path_byte : byte_ff;
      index_in   = cmd.capture ? req_read_index : index_ff;

      ol_in    = ol_ff;
      abs_in   = abs_ff;
      start_in = start_ff;
      cl_in    = cl_ff;
      dp_in    = dp_ff;
      stop_in  = stop_ff;
      k_in     = k_ff;
      done_in  = done_ff;
      rb_in    = rb_ff;

      if (cmd.exec) begin
         if (is_push) begin
            ol_in    = ex_ol;
            abs_in   = e_abs;
            start_in = ex_start;
            cl_in    = ex_cl;
            dp_in    = ex_dp;
            stop_in  = ex_stop;
            k_in     = e_ol - LEN_W'(1);
            done_in  = ex_done;
            rb_in    = '0;
         end else begin
            done_in = 1'b0;
            rb_in   = (LEN_W'(index_ff) < ol_ff) ? rdata_ff : '0;
         end
      end
      if (cmd.walk_step && walk_floor) begin
         ol_in = k_ff;
      end
      if (cmd.walk_check) begin
         if (walk_slash) begin
            ol_in = k_ff;
         end else begin
            k_in = k_ff - LEN_W'(1);
         end
      end

      rsp_len_in   = cmd.rsp_load ? ol_in : rsp_len_ff;
      rsp_done_in  = cmd.rsp_load ? done_in : rsp_done_ff;
      rsp_trunc_in = cmd.rsp_load ? stop_in : rsp_trunc_ff;
      rsp_rb_in    = cmd.rsp_load ? rb_in : rsp_rb_ff;
   end

   // read port: request index on accept, walk pointer while walking back
   assign rd_addr = cmd.walk_step ? AW'(k_ff) : AW'(req_read_index);

   always_ff @(posedge clock) begin
      if (cmd.exec && is_push && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RST;
         ol_ff      <= '0;
         abs_ff     <= 1'b0;
         start_ff   <= 1'b1;
         cl_ff      <= '0;
         dp_ff      <= DOT_NONE;
         stop_ff    <= 1'b0;
      end else begin
         max_len_ff <= max_len_in;
         ol_ff      <= ol_in;
         abs_ff     <= abs_in;
         start_ff   <= start_in;
         cl_ff      <= cl_in;
         dp_ff      <= dp_in;
         stop_ff    <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      byte_ff      <= byte_in;
      index_ff     <= index_in;
      k_ff         <= k_in;
      done_ff      <= done_in;
      rb_ff        <= rb_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_trunc_ff <= rsp_trunc_in;
      rsp_rb_ff    <= rsp_rb_in;
   end

   assign rsp_path_len  = rsp_len_ff;
   assign rsp_path_done = rsp_done_ff;
   assign rsp_truncated = rsp_trunc_ff;
   assign rsp_read_byte = rsp_rb_ff;

endmodule

`default_nettype wire

FILE: rtl/core/path_canonicalizer_top.sv
// Channel | Handshake             | Payload
// req     | req_valid / req_ready | req_type, req_path_byte, req_read_index
// rsp     | rsp_valid / rsp_ready | rsp_path_len, rsp_path_done, rsp_truncated, rsp_read_byte
// csr     | csr_valid / csr_ready | csr_max_len (always ready)
//
// A read or an ordinary path byte is accepted, then executed.
// A ".." component walks the store back one byte at a time (registered
// memory read, then compare) and ends at a slash, the root or an empty path.
// One item is in flight at a time; the next beat is accepted while the
// previous result sits in the output register.
// Synchronous reset clears control state only; the byte store is not cleared.
`default_nettype none

module path_canonicalizer_top
   import pcanon_pkg::*;
#(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [BYTE_W-1:0] req_path_byte,
   input  logic [BYTE_W-1:0] req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [LEN_W-1:0]  rsp_path_len,
   output logic              rsp_path_done,
   output logic              rsp_truncated,
   output logic [BYTE_W-1:0] rsp_read_byte,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LEN_W-1:0]  csr_max_len
);

   pcanon_cmd_type cmd;
   pcanon_sts_type sts;

   assign csr_ready = 1'b1;

   pcanon_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pcanon_dp #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_type),
      .req_path_byte  (req_path_byte),
      .req_read_index (req_read_index),
      .csr_valid      (csr_valid),
      .csr_max_len    (csr_max_len),
      .rsp_path_len   (rsp_path_len),
      .rsp_path_done  (rsp_path_done),
      .rsp_truncated  (rsp_truncated),
      .rsp_read_byte  (rsp_read_byte)
   );

endmodule

`default_nettype wire

FILE: rtl/core/pcanon_chk.sv
`default_nettype none

module pcanon_chk
   import pcanon_pkg::*;
#(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
)
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [LEN_W-1:0]  rsp_path_len,
   input logic              rsp_path_done,
   input logic              rsp_truncated,
   input logic [BYTE_W-1:0] rsp_read_byte
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_path_len, rsp_path_done, rsp_truncated, rsp_read_byte}))
      else $error("result beat changed while stalled");

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_path_len) <= BUF_DEPTH - 1))
      else $error("path length exceeds store capacity");

   a_done_no_byte : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_done |-> (rsp_read_byte == '0))
      else $error("terminating byte returned read data");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind path_canonicalizer_top pcanon_chk #(.BUF_DEPTH(BUF_DEPTH)) u_pcanon_chk (.*);

`default_nettype wire
